[rtl/core/i2cram_pkg.sv]
// Shared types, codes and sizes for the I2C register access master.
`default_nettype none
package i2cram_pkg;

    localparam int PHASE_COUNT_BITS = 16;
    localparam logic [PHASE_COUNT_BITS-1:0] PHASE_COUNT_MAX = '1;

    // Request commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_TICKS    = 1'b1;

    // Sequence stages (upper three bits of the step)
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_ADDR_W = 3'd2;
    localparam logic [2:0] ST_REG    = 3'd3;
    localparam logic [2:0] ST_DATA   = 3'd4;
    localparam logic [2:0] ST_RSTART = 3'd5;
    localparam logic [2:0] ST_ADDR_R = 3'd6;
    localparam logic [2:0] ST_READ   = 3'd7;

    localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       nack_error;
        logic [7:0] read_data;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/i2cram_in_if.sv]
// Request channel: one tick with an optional command and the sampled SDA.
`default_nettype none
interface i2cram_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, command, reg_addr, write_data, sda_in, input ready);
    modport sink   (input valid, command, reg_addr, write_data, sda_in, output ready);
endinterface
`default_nettype wire

[rtl/core/i2cram_out_if.sv]
// Result channel: line drive and status after each tick.
`default_nettype none
interface i2cram_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;
    logic [7:0] read_data;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, nack_error,
                    read_data, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, nack_error,
                    read_data, output ready);
endinterface
`default_nettype wire

[rtl/core/i2cram_seq.sv]
// Transaction sequencer: phase timer, bit shifter and step state machine.
`default_nettype none
module i2cram_seq (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_index,
    input  wire logic [15:0]             i_cfg_data,
    input  wire logic                    i_accept,
    input  wire logic [1:0]              i_command,
    input  wire logic [7:0]              i_reg_addr,
    input  wire logic [7:0]              i_write_data,
    input  wire logic                    i_sda_in,
    output i2cram_pkg::t_result          o_result
);

    logic [6:0]  r_dev_addr;
    logic [15:0] r_tpp;

    logic [5:0]  r_step,     n_step;
    logic [i2cram_pkg::PHASE_COUNT_BITS-1:0] r_cnt, n_cnt, cnt_inc;
    logic [3:0]  r_bit,      n_bit, bit_inc;
    logic [7:0]  r_shift,    n_shift;
    logic        r_is_read,  n_is_read;
    logic [7:0]  r_reg_addr, n_reg_addr;
    logic [7:0]  r_wdata,    n_wdata;
    logic [7:0]  r_last,     n_last;
    logic        r_abort,    n_abort;
    logic        done;
    logic [2:0]  stage, phase, n_stage, n_phase;
    logic        phase_end;
    logic        scl_d, sda_d;

    assign stage   = r_step[5:3];
    assign phase   = r_step[2:0];
    assign bit_inc = r_bit + 4'd1;
    assign cnt_inc = (r_cnt == i2cram_pkg::PHASE_COUNT_MAX) ? r_cnt :
                     r_cnt + {{(i2cram_pkg::PHASE_COUNT_BITS-1){1'b0}}, 1'b1};
    assign phase_end = ({{(32 - i2cram_pkg::PHASE_COUNT_BITS){1'b0}}, cnt_inc} >=
                        {16'd0, r_tpp}) || (cnt_inc == i2cram_pkg::PHASE_COUNT_MAX);

    always_comb begin
        n_step     = r_step;
        n_cnt      = r_cnt;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_is_read  = r_is_read;
        n_reg_addr = r_reg_addr;
        n_wdata    = r_wdata;
        n_last     = r_last;
        n_abort    = r_abort;
        done       = 1'b0;
        if (i_accept) begin
            if (r_step == 6'd0) begin
                if (i_command == i2cram_pkg::CMD_WRITE || i_command == i2cram_pkg::CMD_READ) begin
                    n_is_read  = (i_command == i2cram_pkg::CMD_READ);
                    n_reg_addr = i_reg_addr;
                    n_wdata    = i_write_data;
                    n_abort    = 1'b0;
                    n_bit      = 4'd0;
                    n_cnt      = '0;
                    n_step     = {i2cram_pkg::ST_START, 3'd0};
                end
            end else begin
                n_cnt = cnt_inc;
                if (phase_end) begin
                    n_cnt = '0;
                    unique case (stage) inside
                        i2cram_pkg::ST_IDLE: begin
                            if (phase == 3'd1 || phase == 3'd2) begin
                                n_step = {i2cram_pkg::ST_IDLE, phase + 3'd1};
                            end else begin
                                n_step = 6'd0;
                                done   = (phase == 3'd3);
                            end
                        end
                        i2cram_pkg::ST_START, i2cram_pkg::ST_RSTART: begin
                            if (phase < 3'd2) begin
                                n_step = {stage, phase + 3'd1};
                            end else begin
                                n_step  = {stage + 3'd1, 3'd0};
                                n_bit   = 4'd0;
                                n_shift = {r_dev_addr, (stage == i2cram_pkg::ST_RSTART)};
                            end
                        end
                        i2cram_pkg::ST_READ: begin
                            if (phase > 3'd5) begin
                                n_step = 6'd0;
                            end else if (phase == 3'd2) begin
                                n_bit  = bit_inc;
                                n_step = {i2cram_pkg::ST_READ, (bit_inc[3] ? 3'd3 : 3'd0)};
                            end else if (phase == 3'd5) begin
                                n_last = r_shift;
                                n_step = {i2cram_pkg::ST_IDLE, 3'd1};
                            end else begin
                                if (phase == 3'd1) begin
                                    n_shift = {r_shift[6:0], i_sda_in};
                                end
                                n_step = {i2cram_pkg::ST_READ, phase + 3'd1};
                            end
                        end
                        default: begin
                            // sending stages: address, register, data, address+read
                            if (phase > 3'd5) begin
                                n_step = 6'd0;
                            end else if (phase == 3'd2) begin
                                n_shift = {r_shift[6:0], 1'b0};
                                n_bit   = bit_inc;
                                n_step  = {stage, (bit_inc[3] ? 3'd3 : 3'd0)};
                            end else if (phase == 3'd4) begin
                                if (i_sda_in) begin
                                    n_abort = 1'b1;
                                    if (r_is_read) begin
                                        n_last = i2cram_pkg::BYTE_ALL_ONES;
                                    end
                                end
                                n_step = {stage, 3'd5};
                            end else if (phase == 3'd5) begin
                                if (r_abort) begin
                                    n_step = {i2cram_pkg::ST_IDLE, 3'd1};
                                end else if (stage == i2cram_pkg::ST_ADDR_W) begin
                                    n_step  = {i2cram_pkg::ST_REG, 3'd0};
                                    n_bit   = 4'd0;
                                    n_shift = r_reg_addr;
                                end else if (stage == i2cram_pkg::ST_REG) begin
                                    if (r_is_read) begin
                                        n_step = {i2cram_pkg::ST_RSTART, 3'd0};
                                    end else begin
                                        n_step  = {i2cram_pkg::ST_DATA, 3'd0};
                                        n_bit   = 4'd0;
                                        n_shift = r_wdata;
                                    end
                                end else if (stage == i2cram_pkg::ST_DATA) begin
                                    n_step = {i2cram_pkg::ST_IDLE, 3'd1};
                                end else begin
                                    n_step  = {i2cram_pkg::ST_READ, 3'd0};
                                    n_bit   = 4'd0;
                                    n_shift = 8'd0;
                                end
                            end else begin
                                n_step = {stage, phase + 3'd1};
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Line drive for the step that follows this tick
    assign n_stage = n_step[5:3];
    assign n_phase = n_step[2:0];

    always_comb begin
        scl_d = 1'b1;
        sda_d = 1'b1;
        unique case (n_stage) inside
            i2cram_pkg::ST_IDLE: begin
                if (n_phase == 3'd1) begin
                    scl_d = 1'b0;
                    sda_d = 1'b0;
                end else if (n_phase == 3'd2) begin
                    sda_d = 1'b0;
                end
            end
            i2cram_pkg::ST_START, i2cram_pkg::ST_RSTART: begin
                if (n_phase == 3'd1) begin
                    sda_d = 1'b0;
                end else if (n_phase == 3'd2) begin
                    scl_d = 1'b0;
                    sda_d = 1'b0;
                end
            end
            i2cram_pkg::ST_READ: begin
                if (n_phase <= 3'd5) begin
                    scl_d = (n_phase == 3'd1 || n_phase == 3'd4);
                end
            end
            default: begin
                if (n_phase < 3'd3) begin
                    sda_d = n_shift[7];
                    scl_d = (n_phase == 3'd2);
                end else if (n_phase <= 3'd5) begin
                    scl_d = (n_phase == 3'd4);
                end
            end
        endcase
    end

    always_comb begin
        o_result.scl_out    = scl_d;
        o_result.sda_out    = sda_d;
        o_result.busy_res   = (n_step != 6'd0);
        o_result.done_res   = done;
        o_result.nack_error = done & n_abort;
        o_result.read_data  = n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 7'd104;
            r_tpp      <= 16'd80;
            r_step     <= 6'd0;
            r_cnt      <= '0;
            r_bit      <= 4'd0;
            r_shift    <= 8'd0;
            r_is_read  <= 1'b0;
            r_reg_addr <= 8'd0;
            r_wdata    <= 8'd0;
            r_last     <= i2cram_pkg::BYTE_ALL_ONES;
            r_abort    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    i2cram_pkg::CFG_DEV_ADDR: r_dev_addr <= i_cfg_data[6:0];
                    i2cram_pkg::CFG_TICKS:    r_tpp      <= i_cfg_data;
                endcase
            end
            r_step     <= n_step;
            r_cnt      <= n_cnt;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_is_read  <= n_is_read;
            r_reg_addr <= n_reg_addr;
            r_wdata    <= n_wdata;
            r_last     <= n_last;
            r_abort    <= n_abort;
        end
    end

endmodule
`default_nettype wire

[rtl/core/i2cram_oreg.sv]
// Result register: holds one result until the receiver takes it.
`default_nettype none
module i2cram_oreg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire i2cram_pkg::t_result i_result,
    output logic                     o_can_load,
    i2cram_out_if.source             o_out
);

    logic                r_valid;
    i2cram_pkg::t_result r_res;

    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.scl_out    = r_res.scl_out;
    assign o_out.sda_out    = r_res.sda_out;
    assign o_out.busy_res   = r_res.busy_res;
    assign o_out.done_res   = r_res.done_res;
    assign o_out.nack_error = r_res.nack_error;
    assign o_out.read_data  = r_res.read_data;

endmodule
`default_nettype wire

[rtl/core/i2c_register_access_master_top.sv]
// Top level of the I2C register access master.
//
// Usage: every request on i_in is one clock tick of the I2C timebase and
// carries the sampled SDA level. When the master is idle, a request with
// command write or read starts a single-register transaction; commands that
// arrive while busy are ignored. Each request yields exactly one result on
// o_out: the SCL/SDA drive after that tick, busy, a one-tick done pulse at
// the end of the stop condition, the NACK flag with done, and the last byte
// read (0xFF after reset or an aborted read).
// The result of a request appears in the cycle after it is accepted.
// Throughput: one request per cycle while o_out takes results; the
// sequencer step, phase counter and shifter all update in the accepting
// cycle, and the result register decouples the two channels.
// Stall: while o_out holds an untaken result, i_in.ready follows
// o_out.ready, so a request is still taken in the cycle the result leaves.
// Reset (i_rst_n, synchronous): idle, lines released, device address 104,
// 80 ticks per phase, result register empty.
// Configuration: write i_cfg_index 0 (device address) or 1 (ticks per
// phase) with i_cfg_we only while idle; a phase setting of 0 acts as 1.
`default_nettype none
module i2c_register_access_master_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    i2cram_in_if.sink        i_in,
    i2cram_out_if.source     o_out
);

    logic                accept;
    logic                can_load;
    i2cram_pkg::t_result result;

    assign i_in.ready = can_load;
    assign accept     = i_in.valid && can_load;

    i2cram_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_command    (i_in.command),
        .i_reg_addr   (i_in.reg_addr),
        .i_write_data (i_in.write_data),
        .i_sda_in     (i_in.sda_in),
        .o_result     (result)
    );

    i2cram_oreg u_oreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_result   (result),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire
